@@ rtl/core/lpcr_pkg.sv @@
// Shared constants and types for the LCD page/column repack block.
package lpcr_pkg;

  localparam int LCD_WIDTH   = 160;
  localparam int LCD_HEIGHT  = 43;

  localparam int ROW_BYTES   = (LCD_WIDTH + 7) / 8;
  localparam int PAGES       = (LCD_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH = ROW_BYTES * LCD_HEIGHT;
  localparam int LCD_BYTES   = PAGES * LCD_WIDTH;
  localparam int PAGE_STRIDE = 8 * ROW_BYTES;

  // fixed field widths
  localparam int IDX_W  = 10;
  localparam int ADDR_W = 10;
  localparam int BYTE_W = 8;

  localparam int STORE_AW = $clog2(STORE_DEPTH);
  // address walk runs one page past the last row, so it is sized for the padded image
  localparam int SEQ_AW   = $clog2(PAGES * PAGE_STRIDE + 1);
  localparam int ROW_W    = $clog2(PAGES * 8 + 1);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
  } store_rd_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [BYTE_W-1:0]   data;
  } store_wr_t;

endpackage

@@ rtl/core/lpcr_store.sv @@
// Image byte store: one write port, one registered read port.
module lpcr_store
  import lpcr_pkg::*;
(
  input  logic              clk,
  input  store_wr_t         wr,
  input  store_rd_t         rd,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/lpcr_seq.sv @@
// Read sequencer: index split by repeated subtract, then eight row reads through one adder.
module lpcr_seq
  import lpcr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [IDX_W-1:0]  lcd_index,
  output logic              idle,
  output store_rd_t         rd,
  input  logic [BYTE_W-1:0] rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_err
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_GATH = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [SEQ_AW-1:0] base_r, base_nxt;
  logic [3:0]        k_r, k_nxt;
  logic              pend_r, pend_nxt;
  logic [2:0]        pend_k_r, pend_k_nxt;
  logic              pend_use_r, pend_use_nxt;
  logic [BYTE_W-1:0] acc_r, acc_nxt;
  logic              err_r, err_nxt;
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              oe_r, oe_nxt;

  // shared adder
  logic [SEQ_AW-1:0] add_b;
  logic [SEQ_AW-1:0] add_sum;
  logic              row_ok;
  logic              pix;

  assign add_sum = base_r + add_b;
  assign row_ok  = row_r < ROW_W'(LCD_HEIGHT);
  assign pix     = rd_data[3'd7 - rem_r[2:0]];

  always_comb begin
    state_nxt    = state_r;
    rem_nxt      = rem_r;
    row_nxt      = row_r;
    base_nxt     = base_r;
    k_nxt        = k_r;
    pend_nxt     = 1'b0;
    pend_k_nxt   = pend_k_r;
    pend_use_nxt = pend_use_r;
    acc_nxt      = acc_r;
    err_nxt      = err_r;
    ov_nxt       = ov_r;
    ob_nxt       = ob_r;
    oe_nxt       = oe_r;
    add_b        = SEQ_AW'(PAGE_STRIDE);
    rd.en        = 1'b0;
    rd.addr      = base_r[STORE_AW-1:0];

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    // capture the byte read last cycle
    if (pend_r && pend_use_r && pix) begin
      acc_nxt[pend_k_r] = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          acc_nxt  = '0;
          rem_nxt  = lcd_index;
          row_nxt  = '0;
          base_nxt = '0;
          if (lcd_index >= IDX_W'(LCD_BYTES)) begin
            err_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            err_nxt   = 1'b0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (rem_r >= IDX_W'(LCD_WIDTH)) begin
          rem_nxt  = rem_r - IDX_W'(LCD_WIDTH);
          row_nxt  = row_r + ROW_W'(8);
          base_nxt = add_sum;
        end else begin
          add_b     = SEQ_AW'(rem_r >> 3);
          base_nxt  = add_sum;
          k_nxt     = '0;
          state_nxt = ST_GATH;
        end
      end
      ST_GATH: begin
        if (k_r[3]) begin
          state_nxt = ST_DONE;
        end else begin
          add_b        = SEQ_AW'(ROW_BYTES);
          rd.en        = row_ok;
          pend_nxt     = 1'b1;
          pend_k_nxt   = k_r[2:0];
          pend_use_nxt = row_ok;
          row_nxt      = row_r + ROW_W'(1);
          base_nxt     = add_sum;
          k_nxt        = k_r + 4'd1;
        end
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          ob_nxt    = acc_r;
          oe_nxt    = err_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    row_r      <= row_nxt;
    base_r     <= base_nxt;
    k_r        <= k_nxt;
    pend_k_r   <= pend_k_nxt;
    pend_use_r <= pend_use_nxt;
    acc_r      <= acc_nxt;
    err_r      <= err_nxt;
    ob_r       <= ob_nxt;
    oe_r       <= oe_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_err   = oe_r;

endmodule

@@ rtl/core/lcd_page_column_repack_core.sv @@
// Top level: row-major bitmap store served as LCD page/column bytes.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tdata: image_address, image_byte, lcd_index; tuser: mode
//  out_    | out | out_tvalid/out_tready | tdata: lcd_byte; tuser: range_error
//
// A write item gives no result; in_tready stays high.
// After a read item is accepted, the index is split by one subtract per page,
// eight rows are read from the single store port, and the output register is
// loaded; out_tvalid rises from that register.
// Out-of-range reads go straight to the load.
// Reset clears the sequencer and output valid; the store holds no reset.
// A stalled output holds the next read in its last state until taken.
module lcd_page_column_repack_core
  import lpcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [9:0] image_address, [17:10] image_byte, [27:18] lcd_index
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] lcd_byte
  output logic        out_tuser   // [0] range_error
);

  logic [ADDR_W-1:0] image_address;
  logic [BYTE_W-1:0] image_byte;
  logic [IDX_W-1:0]  lcd_index;
  logic              acc;
  logic              idle;
  store_wr_t         wr;
  store_rd_t         rd;
  logic [BYTE_W-1:0] rd_data;

  assign image_address = in_tdata[9:0];
  assign image_byte    = in_tdata[17:10];
  assign lcd_index     = in_tdata[27:18];

  assign in_tready = idle;
  assign acc       = in_tvalid && in_tready;

  assign wr.en   = acc && (in_tuser == MODE_WRITE) &&
                   (image_address < ADDR_W'(STORE_DEPTH));
  assign wr.addr = image_address[STORE_AW-1:0];
  assign wr.data = image_byte;

  lpcr_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  lpcr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (acc && (in_tuser == MODE_READ)),
    .lcd_index (lcd_index),
    .idle      (idle),
    .rd        (rd),
    .rd_data   (rd_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_err   (out_tuser)
  );

endmodule

@@ rtl/core/lpcr_checker.sv @@
// Port-level checks for the repack core, bound to the top level.
module lpcr_checker
  import lpcr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output item changed while stalled");

  // a read item keeps the block busy on the next cycle
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_READ) |=> !in_tready)
    else $error("ready after read item");

  // a write item never blocks input
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_WRITE) |=> in_tready)
    else $error("busy after write item");

  // flagged results carry zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'd0)
    else $error("range error with nonzero byte");

endmodule

bind lcd_page_column_repack_core lpcr_checker u_lpcr_checker (.*);

@@ sim/tb_top.sv @@
// Self-checking testbench for lcd_page_column_repack_core: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top;
  import lpcr_pkg::*;

  localparam int ITEM_TARGET = 850;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 40;
  localparam int MAX_SHOWN   = 10;

  typedef struct packed {
    logic              range_error;
    logic [BYTE_W-1:0] lcd_byte;
  } lcd_result_t;

  typedef struct packed {
    bit          known;
    lcd_result_t result;
  } pinned_t;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  idx;
    bit                known;
    logic [BYTE_W-1:0] exp_byte;
    logic              exp_err;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;

  lcd_page_column_repack_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // image as seen by accepted writes, and bytes the stimulus has already filled
  logic [BYTE_W-1:0] image_copy [STORE_DEPTH];
  bit                filled_map [STORE_DEPTH];

  lcd_result_t lcd_bytes_due[$];
  pinned_t     pinned_q[$];
  int          fail_count  = 0;
  int          burst_left;
  int          idle_cycles = 0;

  stim_row_t directed_rows [20];

  function automatic lcd_result_t predict_lcd_byte(logic [IDX_W-1:0] idx);
    lcd_result_t       r;
    int                page;
    int                col;
    int                row;
    int                k;
    logic [BYTE_W-1:0] b;
    r = '0;
    if (idx >= LCD_BYTES) begin
      r.range_error = 1'b1;
      return r;
    end
    page = idx / LCD_WIDTH;
    col  = idx % LCD_WIDTH;
    for (k = 0; k < 8; k++) begin
      row = page * 8 + k;
      if (row < LCD_HEIGHT) begin
        b = image_copy[row * ROW_BYTES + col / 8];
        r.lcd_byte[k] = b[7 - col % 8];
      end
    end
    return r;
  endfunction

  task automatic send_item(input logic mode, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] data, input logic [IDX_W-1:0] idx,
                           input pinned_t pin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    if (mode == MODE_WRITE && addr < STORE_DEPTH) filled_map[addr] = 1'b1;
    pinned_q.insert(pinned_q.size(), pin);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, idx, data, addr};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
  endtask

  // receiver: stretches of always-ready, random, sparse and full stall
  int rx_style = 0;
  int rx_left  = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style = $urandom_range(0, 3);
      rx_left  = (rx_style == 3) ? $urandom_range(1, 40) : $urandom_range(1, 200);
    end
    rx_left--;
    case (rx_style)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= 1'b0;
    endcase
  end

  // scoreboard: results are checked before this edge's input item is logged
  always @(posedge clk) begin
    lcd_result_t want;
    pinned_t     pin;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (lcd_bytes_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("unexpected item: lcd_byte=%h range_error=%b", out_tdata, out_tuser);
        end else begin
          want = lcd_bytes_due.pop_front();
          if (out_tdata !== want.lcd_byte || out_tuser !== want.range_error) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
              $display("mismatch: lcd_byte exp %h got %h, range_error exp %b got %b",
                       want.lcd_byte, out_tdata, want.range_error, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pin = pinned_q.pop_front();
        if (in_tuser == MODE_WRITE) begin
          if (in_tdata[9:0] < STORE_DEPTH) image_copy[in_tdata[9:0]] = in_tdata[17:10];
        end else begin
          want = pin.known ? pin.result : predict_lcd_byte(in_tdata[27:18]);
          lcd_bytes_due.insert(lcd_bytes_due.size(), want);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          items_sent;
    int          pick;
    int          i;
    int          page;
    int          col;
    int          row;
    int          row_last;
    int          a;
    logic [IDX_W-1:0] idx;
    pinned_t     pin;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = MODE_WRITE;
    burst_left  = 0;
    items_sent  = 0;
    for (i = 0; i < STORE_DEPTH; i++) begin
      filled_map[i] = 1'b0;
    end

    // columns 0, 1 and 7 of page 0, then the last page, ignored writes and out-of-range reads
    directed_rows = '{
      '{MODE_WRITE, 10'd0,    8'hFF, 10'd1023, 1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 10'd20,   8'h00, 10'd0,    1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 10'd40,   8'h80, 10'd1023, 1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 10'd60,   8'h01, 10'd0,    1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 10'd80,   8'h7F, 10'd512,  1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 10'd100,  8'hFE, 10'd0,    1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 10'd120,  8'hAA, 10'd1023, 1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 10'd140,  8'h55, 10'd0,    1'b0, 8'h00, 1'b0},
      '{MODE_READ,  10'd1023, 8'hFF, 10'd0,    1'b0, 8'h00, 1'b0},
      '{MODE_READ,  10'd0,    8'h00, 10'd7,    1'b0, 8'h00, 1'b0},
      '{MODE_READ,  10'd1023, 8'h00, 10'd1,    1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 10'd819,  8'hFF, 10'd959,  1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 10'd839,  8'h5A, 10'd0,    1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 10'd859,  8'h81, 10'd1023, 1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 10'd860,  8'hFF, 10'd0,    1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 10'd1023, 8'hFF, 10'd1023, 1'b0, 8'h00, 1'b0},
      '{MODE_READ,  10'd0,    8'hFF, 10'd959,  1'b0, 8'h00, 1'b0},
      '{MODE_READ,  10'd512,  8'h00, 10'd952,  1'b0, 8'h00, 1'b0},
      '{MODE_READ,  10'd0,    8'h00, 10'd960,  1'b1, 8'h00, 1'b1},
      '{MODE_READ,  10'd1023, 8'hFF, 10'd1023, 1'b1, 8'h00, 1'b1}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < $size(directed_rows); i++) begin
      pin.known  = directed_rows[i].known;
      pin.result = {directed_rows[i].exp_err, directed_rows[i].exp_byte};
      send_item(directed_rows[i].mode, directed_rows[i].addr, directed_rows[i].data,
                directed_rows[i].idx, pin);
      items_sent++;
    end

    pin = '0;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // write past the image: dropped by the block, not counted
        send_item(MODE_WRITE, ADDR_W'($urandom_range(STORE_DEPTH, 1023)),
                  BYTE_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 1023)), pin);
      end else if (pick < 14) begin
        send_item(MODE_READ, ADDR_W'($urandom_range(0, 1023)), BYTE_W'($urandom_range(0, 255)),
                  IDX_W'($urandom_range(LCD_BYTES, 1023)), pin);
        items_sent++;
      end else if (pick < 30) begin
        send_item(MODE_WRITE, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)),
                  BYTE_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 1023)), pin);
        items_sent++;
      end else begin
        // fill whatever the column still lacks, then read it
        idx      = IDX_W'($urandom_range(0, LCD_BYTES - 1));
        page     = idx / LCD_WIDTH;
        col      = idx % LCD_WIDTH;
        row_last = (page * 8 + 7 < LCD_HEIGHT) ? page * 8 + 7 : LCD_HEIGHT - 1;
        for (row = page * 8; row <= row_last; row++) begin
          a = row * ROW_BYTES + col / 8;
          if (!filled_map[a]) begin
            send_item(MODE_WRITE, ADDR_W'(a), BYTE_W'($urandom_range(0, 255)),
                      IDX_W'($urandom_range(0, 1023)), pin);
            items_sent++;
          end
        end
        send_item(MODE_READ, ADDR_W'($urandom_range(0, 1023)), BYTE_W'($urandom_range(0, 255)),
                  idx, pin);
        items_sent++;
      end
    end

    in_tvalid <= 1'b0;
    while (lcd_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && lcd_bytes_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
